/* rtl/trc_pkg.sv */
// Package for the thermistor RC timing converter: widths, codes and R/T table.
// No dependencies.
package trc_pkg;

  localparam int CaptureDepth = 10;
  localparam int TableEntries = 146;
  localparam int TableFirstDeg = 40;
  localparam int IdxW = $clog2(CaptureDepth);
  localparam int TabIdxW = $clog2(TableEntries);

  typedef enum logic [1:0] {
    FUNC_TICK    = 2'd0,
    FUNC_CAPTURE = 2'd1,
    FUNC_READ    = 2'd2,
    FUNC_NOP     = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    CFG_REF_OHMS = 2'd0,
    CFG_CAP_MIN  = 2'd1,
    CFG_CAP_MAX  = 2'd2
  } cfg_idx_e;

  // operand selection for the shared divider
  typedef enum logic [1:0] {
    DIV_REF_AVG = 2'd0,
    DIV_TH_AVG  = 2'd1,
    DIV_RATIO   = 2'd2,
    DIV_FRAC    = 2'd3
  } div_sel_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] capture_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         phase;
    logic               ref_pin_drive;
    logic               ref_pin_level;
    logic               therm_pin_drive;
    logic               therm_pin_level;
    logic               clear_timer;
    logic signed [15:0] temperature;
    logic               temp_valid;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [31:0] data;
  } cfg_item_t;

  // controller -> datapath
  typedef struct packed {
    logic start_read;   // clear accumulators and begin ring walk
    logic acc_step;     // accumulate entry at walk index
    logic div_start;    // start a division
    div_sel_e div_sel;  // divider operands
    logic search_step;  // compare one table entry
    logic finish;       // set in the output state; not used by the datapath
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_busy;
    logic ref_empty;
    logic therm_empty;
    logic walk_last;
    logic search_last;
  } dp_stat_t;

  function automatic logic [19:0] rt_entry(input logic [TabIdxW-1:0] i);
    logic [19:0] t [TableEntries] = '{
      264279, 250344, 237130, 224603, 212733, 201487, 190836, 180750, 171201, 162163,
      153610, 145516, 137858, 130614, 123761, 117280, 111149, 105351, 99867, 94681,
      89776, 85137, 80750, 76600, 72676, 68963, 65451, 62129, 58986, 56012,
      53198, 50534, 48013, 45627, 43368, 41229, 39204, 37285, 35468, 33747,
      32116, 30570, 29105, 27716, 26399, 25150, 23965, 22842, 21776, 20764,
      19783, 18892, 18026, 17204, 16423, 15681, 14976, 14306, 13669, 13063,
      12487, 11939, 11418, 10921, 10449, 10000, 9571, 9164, 8775, 8405,
      8052, 7716, 7396, 7090, 6798, 6520, 6255, 6002, 5760, 5529,
      5309, 5098, 4897, 4704, 4521, 4345, 4177, 4016, 3863, 3716,
      3588, 3440, 3311, 3188, 3069, 2956, 2848, 2744, 2644, 2548,
      2457, 2369, 2284, 2204, 2126, 2051, 1980, 1911, 1845, 1782,
      1721, 1663, 1606, 1552, 1500, 1450, 1402, 1356, 1312, 1269,
      1228, 1188, 1150, 1113, 1078, 1044, 1011, 979, 948, 919,
      891, 863, 837, 811, 787, 763, 740, 718, 697, 676,
      657, 637, 619, 601, 584, 567
    };
    logic [19:0] r;
    r = '0;
    if (32'(i) < TableEntries) r = t[i];
    return r;
  endfunction

endpackage

/* rtl/trc_if.sv */
// Valid/ready channel interface carrying one payload type.
// Depends on trc_pkg for payload types.
interface trc_in_if;
  logic                valid;
  logic                ready;
  trc_pkg::in_item_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface trc_out_if;
  logic                valid;
  logic                ready;
  trc_pkg::out_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface trc_cfg_if;
  logic                valid;
  logic                ready;
  trc_pkg::cfg_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/trc_divider.sv */
// Restoring divider, one quotient bit per cycle, 64-bit dividend, 41-bit divisor.
// No package dependencies.
module trc_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [40:0] divisor_i,
  output logic        busy_o,
  output logic [63:0] quot_o
);

  logic [63:0] quot_q, quot_d;
  logic [41:0] rem_q, rem_d;
  logic [40:0] div_q, div_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [41:0] sh;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    sh     = {rem_q[40:0], quot_q[63]};
    if (start_i) begin
      quot_d = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
      cnt_d  = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (sh >= {1'b0, div_q}) begin
        rem_d  = sh - {1'b0, div_q};
        quot_d = {quot_q[62:0], 1'b1};
      end else begin
        rem_d  = sh;
        quot_d = {quot_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    div_q  <= div_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;
endmodule

/* rtl/trc_datapath.sv */
// Datapath: capture rings, phase sequencer, averaging, ratio and table search.
// Depends on trc_pkg and trc_divider.
module trc_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_take_i,
  input  trc_pkg::in_item_t   item_i,
  input  logic                cfg_take_i,
  input  trc_pkg::cfg_item_t  cfg_i,
  input  trc_pkg::dp_cmd_t    cmd_i,
  output trc_pkg::dp_stat_t   stat_o,
  output logic [1:0]          phase_o,
  output logic                clear_o,
  output logic signed [15:0]  temp_o
);
  import trc_pkg::*;

  logic [19:0] ref_ohms_q;
  logic [31:0] cap_min_q, cap_max_q;
  logic [1:0]  phase_q;
  logic [2:0]  tmo_q;
  logic        clr_q;
  logic [31:0] ref_ring_q [CaptureDepth];
  logic [31:0] th_ring_q  [CaptureDepth];
  logic [IdxW-1:0] ref_wi_q, th_wi_q;

  // read walk
  logic [IdxW-1:0] walk_q;
  logic [35:0] ref_sum_q, th_sum_q;
  logic [4:0]  ref_cnt_q, th_cnt_q;
  logic [31:0] ref_avg_q, th_avg_q;
  logic [40:0] r_q;
  logic [TabIdxW-1:0] sidx_q, best_q;
  div_sel_e    sel_q;
  logic        busy_prev_q;
  logic signed [15:0] temp_o_q;

  logic        div_busy;
  logic [63:0] quot;
  logic [63:0] dvd;
  logic [40:0] dvs;
  logic        frac_neg;
  logic signed [39:0] tbase, tfull;

  logic [31:0] rv, tv;
  logic        rok, tok;
  assign rv  = ref_ring_q[walk_q];
  assign tv  = th_ring_q[walk_q];
  assign rok = (rv >= cap_min_q) && (rv <= cap_max_q);
  assign tok = (tv >= cap_min_q) && (tv <= cap_max_q);

  logic [19:0] t_i, t_i1;
  assign t_i  = rt_entry(best_q);
  assign t_i1 = rt_entry(best_q + TabIdxW'(1));
  // ratio above the first entry: extrapolate toward colder degrees
  assign frac_neg = (r_q > 41'(t_i));

  always_comb begin
    dvd = '0;
    dvs = 41'd1;
    unique case (cmd_i.div_sel)
      DIV_REF_AVG: begin
        dvd = 64'(ref_sum_q);
        dvs = 41'(ref_cnt_q);
      end
      DIV_TH_AVG: begin
        dvd = 64'(th_sum_q);
        dvs = 41'(th_cnt_q);
      end
      DIV_RATIO: begin
        dvd = 64'(ref_ohms_q) * 64'(th_avg_q);
        dvs = 41'(ref_avg_q);
      end
      default: begin
        dvs = 41'(t_i - t_i1);
        // negative fraction: take the ceiling of the magnitude so that negation floors
        if (frac_neg) dvd = (64'(r_q - 41'(t_i)) << 8) + 64'(dvs) - 64'd1;
        else dvd = 64'(41'(t_i) - r_q) << 8;
      end
    endcase
  end

  trc_divider u_div (
    .clk_i,
    .rst_ni,
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  assign stat_o.div_busy    = div_busy || cmd_i.div_start;
  assign stat_o.ref_empty   = (ref_cnt_q == '0);
  assign stat_o.therm_empty = (th_cnt_q == '0);
  assign stat_o.walk_last   = (32'(walk_q) == CaptureDepth - 1);
  assign stat_o.search_last = (32'(sidx_q) == TableEntries - 1);

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_ohms_q <= 20'd10000;
      cap_min_q  <= '0;
      cap_max_q  <= '1;
    end else if (cfg_take_i) begin
      unique case (cfg_i.index)
        CFG_REF_OHMS: ref_ohms_q <= cfg_i.data[19:0];
        CFG_CAP_MIN:  cap_min_q  <= cfg_i.data;
        CFG_CAP_MAX:  cap_max_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // phase sequencer and rings
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= 2'd2;
      tmo_q    <= '0;
      clr_q    <= 1'b0;
      ref_wi_q <= '0;
      th_wi_q  <= '0;
      for (int k = 0; k < CaptureDepth; k++) begin
        ref_ring_q[k] <= '0;
        th_ring_q[k]  <= '0;
      end
    end else if (item_take_i) begin
      clr_q <= 1'b0;
      if (item_i.func == FUNC_TICK) begin
        if (tmo_q <= 3'd1) begin
          unique case (phase_q)
            2'd0: begin phase_q <= 2'd1; tmo_q <= 3'd2; clr_q <= 1'b1; end
            2'd1: begin phase_q <= 2'd2; tmo_q <= 3'd1; end
            2'd2: begin phase_q <= 2'd3; tmo_q <= 3'd1; clr_q <= 1'b1; end
            default: begin phase_q <= 2'd0; tmo_q <= 3'd4; end
          endcase
        end else begin
          tmo_q <= tmo_q - 3'd1;
        end
      end else if (item_i.func == FUNC_CAPTURE) begin
        if (phase_q == 2'd1) begin
          ref_ring_q[ref_wi_q] <= item_i.capture_value;
          ref_wi_q <= (32'(ref_wi_q) == CaptureDepth - 1) ? '0 : ref_wi_q + IdxW'(1);
        end else if (phase_q == 2'd3) begin
          th_ring_q[th_wi_q] <= item_i.capture_value;
          th_wi_q <= (32'(th_wi_q) == CaptureDepth - 1) ? '0 : th_wi_q + IdxW'(1);
        end
      end
    end
  end

  always_comb begin
    tbase = (40'(best_q) - 40'(TableFirstDeg)) << 8;
    if (32'(best_q) >= TableEntries - 1) tfull = tbase;
    else if (frac_neg) tfull = tbase - 40'(quot[35:0]);
    else tfull = tbase + 40'(quot[35:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) busy_prev_q <= 1'b0;
    else busy_prev_q <= div_busy;
  end

  // read datapath; divider results are latched in the cycle busy falls
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) sel_q <= cmd_i.div_sel;
    if (cmd_i.acc_step) begin
      if (rok) begin
        ref_sum_q <= ref_sum_q + 36'(rv);
        ref_cnt_q <= ref_cnt_q + 5'd1;
      end
      if (tok) begin
        th_sum_q <= th_sum_q + 36'(tv);
        th_cnt_q <= th_cnt_q + 5'd1;
      end
      walk_q <= walk_q + IdxW'(1);
    end
    if (cmd_i.search_step) begin
      if (41'(rt_entry(sidx_q)) >= r_q) best_q <= sidx_q;
      sidx_q <= sidx_q + TabIdxW'(1);
    end
    if (cmd_i.div_start && cmd_i.div_sel == DIV_RATIO && ref_avg_q == '0) begin
      r_q <= 41'h100_0000_0000;
    end
    if (busy_prev_q && !div_busy) begin
      unique case (sel_q)
        DIV_REF_AVG: ref_avg_q <= quot[31:0];
        DIV_TH_AVG:  th_avg_q  <= quot[31:0];
        DIV_RATIO: begin
          if (ref_avg_q != '0)
            r_q <= (quot > 64'h100_0000_0000) ? 41'h100_0000_0000 : quot[40:0];
          sidx_q <= '0;
          best_q <= '0;
        end
        default: begin
          if (tfull > 32767) temp_o_q <= 16'sh7fff;
          else if (tfull < -32768) temp_o_q <= 16'sh8000;
          else temp_o_q <= tfull[15:0];
        end
      endcase
    end
    if (cmd_i.start_read) begin
      walk_q    <= '0;
      ref_sum_q <= '0;
      th_sum_q  <= '0;
      ref_cnt_q <= '0;
      th_cnt_q  <= '0;
      temp_o_q  <= '0;
    end
  end

  assign temp_o  = temp_o_q;
  assign phase_o = phase_q;
  assign clear_o = clr_q;
endmodule

/* rtl/trc_ctrl.sv */
// Controller: item sequencing, read sequence and result register.
// Depends on trc_pkg.
module trc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  trc_pkg::in_item_t  in_data_i,
  output logic               in_ready_o,
  output logic               item_take_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               out_tv_o,
  output logic               out_read_o,
  output trc_pkg::dp_cmd_t   cmd_o,
  input  trc_pkg::dp_stat_t  stat_i
);
  import trc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_WALK, S_DIV_REF, S_DIV_TH, S_DIV_R, S_SEARCH, S_DIV_F, S_OUT
  } state_e;

  state_e state_q;
  logic   out_valid_q, tv_q, rd_q, wait_q;

  assign in_ready_o  = (state_q == S_IDLE) && !out_valid_q;
  assign item_take_o = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_tv_o    = tv_q;
  assign out_read_o  = rd_q;

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE:   cmd_o.start_read = item_take_o && (in_data_i.func == FUNC_READ);
      S_WALK:   cmd_o.acc_step = 1'b1;
      S_DIV_REF: begin cmd_o.div_sel = DIV_REF_AVG; cmd_o.div_start = !wait_q; end
      S_DIV_TH:  begin cmd_o.div_sel = DIV_TH_AVG;  cmd_o.div_start = !wait_q; end
      S_DIV_R:   begin cmd_o.div_sel = DIV_RATIO;   cmd_o.div_start = !wait_q; end
      S_SEARCH: cmd_o.search_step = 1'b1;
      S_DIV_F:   begin cmd_o.div_sel = DIV_FRAC;    cmd_o.div_start = !wait_q; end
      default:  cmd_o.finish = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      tv_q        <= 1'b0;
      rd_q        <= 1'b0;
      wait_q      <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (item_take_o) begin
          tv_q <= 1'b0;
          rd_q <= 1'b0;
          if (in_data_i.func == FUNC_READ) state_q <= S_WALK;
          else out_valid_q <= 1'b1;
        end
        S_WALK: if (stat_i.walk_last) begin
          wait_q  <= 1'b0;
          state_q <= S_DIV_REF;
        end
        S_DIV_REF, S_DIV_TH, S_DIV_R, S_DIV_F: begin
          if (state_q == S_DIV_REF && (stat_i.ref_empty || stat_i.therm_empty)) begin
            state_q <= S_OUT;
          end else if (!wait_q) begin
            wait_q <= 1'b1;
          end else if (!stat_i.div_busy) begin
            wait_q <= 1'b0;
            unique case (state_q)
              S_DIV_REF: state_q <= S_DIV_TH;
              S_DIV_TH:  state_q <= S_DIV_R;
              S_DIV_R:   state_q <= S_SEARCH;
              default: begin
                tv_q    <= 1'b1;
                state_q <= S_OUT;
              end
            endcase
          end
        end
        S_SEARCH: if (stat_i.search_last) state_q <= S_DIV_F;
        default: begin
          rd_q        <= 1'b1;
          out_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end
      endcase
    end
  end
endmodule

/* rtl/thermistor_rc_timing_converter_unit.sv */
// Thermistor RC timing converter, top level.
// Tick, capture and no-op items: result presented in the cycle after transfer.
// Read items: result follows the ring walk, the serial divider used four times
// (skipped if a ring holds no valid capture) and the one-entry-per-cycle table search; one item at a time.
// Async active-low reset: phase 2, timeout 0, rings cleared, config registers to defaults.
module thermistor_rc_timing_converter_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  trc_in_if.sink     in_if,
  trc_out_if.source  out_if,
  trc_cfg_if.sink    cfg_if
);
  import trc_pkg::*;

  logic      item_take, tv, rd, clr;
  logic [1:0] phase;
  logic signed [15:0] temp;
  dp_cmd_t   cmd;
  dp_stat_t  stat;

  assign cfg_if.ready = 1'b1;

  trc_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i  (in_if.valid),
    .in_data_i   (in_if.data),
    .in_ready_o  (in_if.ready),
    .item_take_o (item_take),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_tv_o    (tv),
    .out_read_o  (rd),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  trc_datapath u_dp (
    .clk_i, .rst_ni,
    .item_take_i (item_take),
    .item_i      (in_if.data),
    .cfg_take_i  (cfg_if.valid && cfg_if.ready),
    .cfg_i       (cfg_if.data),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .phase_o     (phase),
    .clear_o     (clr),
    .temp_o      (temp)
  );

  always_comb begin
    out_if.data.phase           = phase;
    out_if.data.ref_pin_drive   = (phase != 2'd3);
    out_if.data.ref_pin_level   = (phase == 2'd1);
    out_if.data.therm_pin_drive = (phase != 2'd1);
    out_if.data.therm_pin_level = (phase == 2'd3);
    out_if.data.clear_timer     = clr;
    out_if.data.temperature     = (rd && tv) ? temp : 16'sd0;
    out_if.data.temp_valid      = rd && tv;
  end

`ifndef ASSERT_OFF
  a_no_take_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> !in_if.ready) else $error("input taken while result pending");
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.data.temp_valid) |-> (out_if.data.temperature == 16'sd0))
    else $error("temperature nonzero without valid");
  a_clear_charge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.data.clear_timer) |->
      (out_if.data.phase == 2'd1 || out_if.data.phase == 2'd3))
    else $error("timer clear outside charge phase");
`endif
endmodule
